// ===== hdl/cte_pkg.sv =====
package cte_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int UNIT_ID_BITS = 8;
	localparam int PORT_BITS    = 8;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	// wide enough for a port and a 9-bit protected count, plus headroom
	localparam int CMP_W   = ((PORT_BITS > 9) ? PORT_BITS : 9) + 1;

	// operation codes
	localparam logic [2:0] F_CONNECT      = 3'd0;
	localparam logic [2:0] F_DISCONNECT   = 3'd1;
	localparam logic [2:0] F_SOURCE_OF    = 3'd2;
	localparam logic [2:0] F_SINKS_TERM   = 3'd3;
	localparam logic [2:0] F_SINKS_UNIT   = 3'd4;
	localparam logic [2:0] F_SOURCES_UNIT = 3'd5;
	localparam logic [2:0] F_REMOVE_UNIT  = 3'd6;
	localparam logic [2:0] F_UNUSED       = 3'd7;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ALREADY   = 3'd1;
	localparam logic [2:0] ST_OTHER_SRC = 3'd2;
	localparam logic [2:0] ST_NOT_CONN  = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef logic [UNIT_ID_BITS-1:0] unit_t;
	typedef logic [PORT_BITS-1:0]    port_t;

	typedef struct packed {
		unit_t su;
		port_t sp;
		unit_t ku;
		port_t kp;
	} link_t;

	localparam int ENTRY_W = $bits(link_t);

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic start_scan;
		logic scan_hold;
		logic scan_end;
		logic fin_done;
	} status_t;

	function automatic unit_t to_unit(input logic [7:0] v);
		logic [UNIT_ID_BITS+7:0] w;
		w = {{UNIT_ID_BITS{1'b0}}, v};
		return w[UNIT_ID_BITS-1:0];
	endfunction

	function automatic port_t to_port(input logic [7:0] v);
		logic [PORT_BITS+7:0] w;
		w = {{PORT_BITS{1'b0}}, v};
		return w[PORT_BITS-1:0];
	endfunction

	function automatic logic [7:0] unit_out(input unit_t u);
		logic [UNIT_ID_BITS+7:0] w;
		w = {8'b0, u};
		return w[7:0];
	endfunction

	function automatic logic [7:0] port_out(input port_t p);
		logic [PORT_BITS+7:0] w;
		w = {8'b0, p};
		return w[7:0];
	endfunction

endpackage

// ===== hdl/cte_ram.sv =====
module cte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/cte_ctrl.sv =====
module cte_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cte_pkg::status_t st,
	output cte_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = st.start_scan ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (!st.scan_hold && st.scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				if (st.fin_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/cte_dp.sv =====
module cte_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  cte_pkg::cmd_t      cmd,
	output cte_pkg::status_t   st,
	input  logic [2:0]         func,
	input  logic [7:0]         src_unit,
	input  logic [7:0]         src_port,
	input  logic [7:0]         sink_unit,
	input  logic [7:0]         sink_port,
	input  logic [8:0]         protected_in_ports,
	input  logic [8:0]         protected_out_ports,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         term_unit,
	output logic [7:0]         term_port,
	output logic               last
);

	localparam int IDX_W = cte_pkg::IDX_W;
	localparam int CNT_W = cte_pkg::CNT_W;
	localparam int CMP_W = cte_pkg::CMP_W;
	localparam int PB    = cte_pkg::PORT_BITS;

	// operation registers
	logic [2:0]     func_q;
	cte_pkg::unit_t su_q, ku_q;
	cte_pkg::port_t sp_q, kp_q;
	logic [8:0]     pin_q, pout_q;
	logic           ascend_q;

	// scan control
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] eval_idx_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] wr_idx_q;
	logic             dropped_q;

	// held hit (first match or list look-ahead)
	logic             pend_vld_q;
	cte_pkg::unit_t   pend_unit_q;
	cte_pkg::port_t   pend_port_q;

	// result register
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       term_unit_q, term_port_q;
	logic             last_q;

	// memory port
	logic                         re, we;
	logic [IDX_W-1:0]             raddr, waddr;
	logic [cte_pkg::ENTRY_W-1:0]  wdata, rdata;
	cte_pkg::link_t               e, new_link;

	logic in_list, is_list_q, is_compact_q, is_first_q;
	logic m_sink, m_src, lhit, drop, early, hold, step, out_full, fin_done;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] start_idx, next_idx;
	cte_pkg::unit_t   item_unit;
	cte_pkg::port_t   item_port;
	logic [2:0]       fin_status;
	logic [7:0]       fin_unit, fin_port;
	logic             conn_ok;

	cte_ram #(
		.WIDTH(cte_pkg::ENTRY_W),
		.DEPTH(cte_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign e = cte_pkg::link_t'(rdata);
	assign new_link = '{su: su_q, sp: sp_q, ku: ku_q, kp: kp_q};

	assign in_list = (func == cte_pkg::F_SINKS_TERM) || (func == cte_pkg::F_SINKS_UNIT) ||
		(func == cte_pkg::F_SOURCES_UNIT);
	assign is_list_q = (func_q == cte_pkg::F_SINKS_TERM) ||
		(func_q == cte_pkg::F_SINKS_UNIT) || (func_q == cte_pkg::F_SOURCES_UNIT);
	assign is_compact_q = (func_q == cte_pkg::F_DISCONNECT) ||
		(func_q == cte_pkg::F_REMOVE_UNIT);
	assign is_first_q = (func_q == cte_pkg::F_CONNECT) || (func_q == cte_pkg::F_SOURCE_OF);

	assign m_sink = (e.ku == ku_q) && (e.kp == kp_q);
	assign m_src  = (e.su == su_q) && (e.sp == sp_q);

	always_comb begin
		lhit = 1'b0;
		drop = 1'b0;
		unique case (func_q)
			cte_pkg::F_SINKS_TERM:   lhit = m_src;
			cte_pkg::F_SINKS_UNIT:   lhit = (e.su == su_q);
			cte_pkg::F_SOURCES_UNIT: lhit = (e.ku == su_q);
			cte_pkg::F_DISCONNECT:   drop = m_src && m_sink && !dropped_q;
			cte_pkg::F_REMOVE_UNIT: begin
				drop = ((e.su == su_q) &&
					({{(CMP_W-PB){1'b0}}, e.sp} >= {{(CMP_W-9){1'b0}}, pin_q})) ||
					((e.ku == su_q) &&
					({{(CMP_W-PB){1'b0}}, e.kp} >= {{(CMP_W-9){1'b0}}, pout_q}));
			end
			default: begin
				lhit = 1'b0;
				drop = 1'b0;
			end
		endcase
	end

	assign item_unit = (func_q == cte_pkg::F_SOURCES_UNIT) ? e.su : e.ku;
	assign item_port = (func_q == cte_pkg::F_SOURCES_UNIT) ? e.sp : e.kp;

	assign out_full = out_valid_q && !out_ready;
	assign early    = is_first_q && m_sink;
	// a list hit must push the held hit out first; wait if the result reg is busy
	assign hold     = cmd.scan && is_list_q && lhit && pend_vld_q && out_full;
	assign step     = cmd.scan && !hold && !st.scan_end;
	assign fin_done = !out_full;

	assign st.start_scan = (count_q != '0) && (func != cte_pkg::F_UNUSED);
	assign st.scan_hold  = hold;
	assign st.scan_end   = early || (left_q == CNT_W'(1));
	assign st.fin_done   = fin_done;

	assign cnt_m1    = count_q - CNT_W'(1);
	assign start_idx = in_list ? cnt_m1[IDX_W-1:0] : '0;
	assign next_idx  = ascend_q ? (eval_idx_q + IDX_W'(1)) : (eval_idx_q - IDX_W'(1));

	assign re    = cmd.load || step;
	assign raddr = cmd.load ? start_idx : next_idx;

	assign conn_ok = (func_q == cte_pkg::F_CONNECT) && !pend_vld_q &&
		(count_q != CNT_W'(cte_pkg::TABLE_DEPTH));

	// compaction writes trail the read pointer; a new link goes at the end
	always_comb begin
		we    = 1'b0;
		waddr = wr_idx_q[IDX_W-1:0];
		wdata = e;
		if (cmd.scan && is_compact_q && !drop) begin
			we = 1'b1;
		end else if (cmd.finish && fin_done && conn_ok) begin
			we    = 1'b1;
			waddr = count_q[IDX_W-1:0];
			wdata = new_link;
		end
	end

	always_comb begin
		fin_status = cte_pkg::ST_NONE;
		fin_unit   = '0;
		fin_port   = '0;
		priority case (1'b1)
			func_q == cte_pkg::F_CONNECT: begin
				if (pend_vld_q) begin
					fin_status = ((pend_unit_q == su_q) && (pend_port_q == sp_q)) ?
						cte_pkg::ST_ALREADY : cte_pkg::ST_OTHER_SRC;
					fin_unit = cte_pkg::unit_out(pend_unit_q);
					fin_port = cte_pkg::port_out(pend_port_q);
				end else if (conn_ok) begin
					fin_status = cte_pkg::ST_OK;
				end else begin
					fin_status = cte_pkg::ST_FULL;
				end
			end
			func_q == cte_pkg::F_DISCONNECT:
				fin_status = dropped_q ? cte_pkg::ST_OK : cte_pkg::ST_NOT_CONN;
			func_q == cte_pkg::F_REMOVE_UNIT:
				fin_status = cte_pkg::ST_OK;
			(func_q == cte_pkg::F_SOURCE_OF) || is_list_q: begin
				if (pend_vld_q) begin
					fin_status = cte_pkg::ST_OK;
					fin_unit   = cte_pkg::unit_out(pend_unit_q);
					fin_port   = cte_pkg::port_out(pend_port_q);
				end
			end
			default: fin_status = cte_pkg::ST_NONE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_vld_q  <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				pend_vld_q <= 1'b0;
				dropped_q  <= 1'b0;
			end
			if (cmd.scan && !hold) begin
				if ((func_q == cte_pkg::F_DISCONNECT) && drop) begin
					dropped_q <= 1'b1;
				end
				if (early || (is_list_q && lhit)) begin
					pend_vld_q <= 1'b1;
				end
				if (is_list_q && lhit && pend_vld_q) begin
					out_valid_q <= 1'b1;
				end
			end
			if (cmd.finish && fin_done) begin
				out_valid_q <= 1'b1;
				if (conn_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (is_compact_q) begin
					count_q <= wr_idx_q;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			su_q       <= cte_pkg::to_unit(src_unit);
			sp_q       <= cte_pkg::to_port(src_port);
			ku_q       <= cte_pkg::to_unit(sink_unit);
			kp_q       <= cte_pkg::to_port(sink_port);
			pin_q      <= protected_in_ports;
			pout_q     <= protected_out_ports;
			ascend_q   <= !in_list;
			eval_idx_q <= start_idx;
			left_q     <= count_q;
			wr_idx_q   <= '0;
		end
		if (cmd.scan && !hold) begin
			if (is_compact_q && !drop) begin
				wr_idx_q <= wr_idx_q + CNT_W'(1);
			end
			if (step) begin
				eval_idx_q <= next_idx;
				left_q     <= left_q - CNT_W'(1);
			end
			if (early) begin
				pend_unit_q <= e.su;
				pend_port_q <= e.sp;
			end else if (is_list_q && lhit) begin
				pend_unit_q <= item_unit;
				pend_port_q <= item_port;
			end
			if (is_list_q && lhit && pend_vld_q) begin
				status_q    <= cte_pkg::ST_OK;
				term_unit_q <= cte_pkg::unit_out(pend_unit_q);
				term_port_q <= cte_pkg::port_out(pend_port_q);
				last_q      <= 1'b0;
			end
		end
		if (cmd.finish && fin_done) begin
			status_q    <= fin_status;
			term_unit_q <= fin_unit;
			term_port_q <= fin_port;
			last_q      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign term_unit = term_unit_q;
	assign term_port = term_port_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(cte_pkg::TABLE_DEPTH))
		else $error("link count beyond table depth");

	a_scan_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (left_q != '0))
		else $error("scan running with no entries left");

	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (wr_idx_q <= count_q))
		else $error("compaction pointer past table end");

	a_hold_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && hold) |=> ($stable(eval_idx_q) && $stable(left_q) && cmd.scan))
		else $error("scan moved while held on a busy result");
`endif

endmodule

// ===== hdl/connection_table_engine_unit.sv =====
// Connection table engine: ordered table of source->sink links in one RAM.
// Lists stream one result per scanned hit; the final result carries last.
// The scan reads one link RAM entry per cycle unless a list hit waits on a busy result;
// a new operation is taken only once the previous one has posted its final result.
// Reset: link count cleared at once; RAM contents are not cleared (never used past count).
module connection_table_engine_unit (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [7:0] src_unit,
	input  logic [7:0] src_port,
	input  logic [7:0] sink_unit,
	input  logic [7:0] sink_port,
	input  logic [8:0] protected_in_ports,
	input  logic [8:0] protected_out_ports,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] term_unit,
	output logic [7:0] term_port,
	output logic       last
);

	// Controller sequences each transaction: load operands and issue the
	// first RAM read, scan one entry per cycle unless a list hit waits on
	// a busy result, then post the final result. Scan runs ascending for
	// lookups, connect and compaction, and descending for list operations.
	cte_pkg::cmd_t    cmd;
	cte_pkg::status_t st;

	cte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	// Datapath: link RAM, scan/compaction pointers, held hit and the
	// result register. A list result is emitted one hit late so the
	// final one can be marked last; compaction writes kept entries back
	// behind the read pointer during the same scan.
	cte_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.func               (func),
		.src_unit           (src_unit),
		.src_port           (src_port),
		.sink_unit          (sink_unit),
		.sink_port          (sink_port),
		.protected_in_ports (protected_in_ports),
		.protected_out_ports(protected_out_ports),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.term_unit          (term_unit),
		.term_port          (term_port),
		.last               (last)
	);

endmodule

// ===== tb/connection_table_engine_unit_test.sv =====
`timescale 1ns / 100ps

typedef struct packed {
	logic [2:0] status;
	logic [7:0] tu;
	logic [7:0] tp;
	logic       last;
} outcome_t;

// Mirror of the link table plus the results still owed by the block.
class conn_table_tracker;
	cte_pkg::link_t links [cte_pkg::TABLE_DEPTH];
	int             link_cnt;
	outcome_t       awaited [$];
	int             fault_count;

	function new();
		link_cnt = 0;
		fault_count = 0;
	endfunction

	function void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endfunction

	function void queue_outcome(logic [2:0] st, logic [7:0] tu, logic [7:0] tp, logic lst);
		outcome_t o;
		o.status = st;
		o.tu = tu;
		o.tp = tp;
		o.last = lst;
		awaited.push_back(o);
	endfunction

	function int sink_index(cte_pkg::unit_t ku, cte_pkg::port_t kp);
		for (int i = 0; i < link_cnt; i++)
			if (links[i].ku == ku && links[i].kp == kp)
				return i;
		return -1;
	endfunction

	// Apply one accepted request to the mirror and queue what it must produce.
	function void take_request(logic [2:0] op, cte_pkg::unit_t su, cte_pkg::port_t sp,
			cte_pkg::unit_t ku, cte_pkg::port_t kp, logic [8:0] pin, logic [8:0] pout);
		int f;
		int w;
		logic hit;
		cte_pkg::link_t e;
		int found [$];
		case (op)
			cte_pkg::F_CONNECT: begin
				f = sink_index(ku, kp);
				if (f >= 0) begin
					queue_outcome((links[f].su == su && links[f].sp == sp) ?
						cte_pkg::ST_ALREADY : cte_pkg::ST_OTHER_SRC,
						links[f].su, links[f].sp, 1'b1);
				end else if (link_cnt >= cte_pkg::TABLE_DEPTH) begin
					queue_outcome(cte_pkg::ST_FULL, '0, '0, 1'b1);
				end else begin
					links[link_cnt] = cte_pkg::link_t'({su, sp, ku, kp});
					link_cnt++;
					queue_outcome(cte_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			cte_pkg::F_DISCONNECT: begin
				f = -1;
				for (int i = 0; i < link_cnt && f < 0; i++)
					if (links[i] == cte_pkg::link_t'({su, sp, ku, kp}))
						f = i;
				if (f < 0) begin
					queue_outcome(cte_pkg::ST_NOT_CONN, '0, '0, 1'b1);
				end else begin
					for (int i = f; i + 1 < link_cnt; i++)
						links[i] = links[i + 1];
					link_cnt--;
					queue_outcome(cte_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			cte_pkg::F_SOURCE_OF: begin
				f = sink_index(ku, kp);
				if (f >= 0)
					queue_outcome(cte_pkg::ST_OK, links[f].su, links[f].sp, 1'b1);
				else
					queue_outcome(cte_pkg::ST_NONE, '0, '0, 1'b1);
			end
			cte_pkg::F_SINKS_TERM, cte_pkg::F_SINKS_UNIT, cte_pkg::F_SOURCES_UNIT: begin
				// lists walk the table from the newest entry down
				for (int i = link_cnt - 1; i >= 0; i--) begin
					e = links[i];
					if (op == cte_pkg::F_SINKS_TERM)
						hit = (e.su == su && e.sp == sp);
					else if (op == cte_pkg::F_SINKS_UNIT)
						hit = (e.su == su);
					else
						hit = (e.ku == su);
					if (hit)
						found.push_back(i);
				end
				if (found.size() == 0) begin
					queue_outcome(cte_pkg::ST_NONE, '0, '0, 1'b1);
				end else begin
					foreach (found[j]) begin
						e = links[found[j]];
						if (op == cte_pkg::F_SOURCES_UNIT)
							queue_outcome(cte_pkg::ST_OK, e.su, e.sp, j == found.size() - 1);
						else
							queue_outcome(cte_pkg::ST_OK, e.ku, e.kp, j == found.size() - 1);
					end
				end
			end
			cte_pkg::F_REMOVE_UNIT: begin
				w = 0;
				for (int i = 0; i < link_cnt; i++) begin
					e = links[i];
					if (!((e.su == su && int'(e.sp) >= int'(pin)) ||
							(e.ku == su && int'(e.kp) >= int'(pout)))) begin
						links[w] = e;
						w++;
					end
				end
				link_cnt = w;
				queue_outcome(cte_pkg::ST_OK, '0, '0, 1'b1);
			end
			default: begin
				queue_outcome(cte_pkg::ST_NONE, '0, '0, 1'b1);
			end
		endcase
	endfunction

	function void match_result(logic [2:0] st, logic [7:0] tu, logic [7:0] tp, logic lst);
		outcome_t want;
		if (awaited.size() == 0) begin
			note_fault($sformatf("unexpected result status=%0d unit=%0d port=%0d last=%0b",
				st, tu, tp, lst));
			return;
		end
		want = awaited.pop_front();
		if (want.status !== st || want.tu !== tu || want.tp !== tp || want.last !== lst)
			note_fault($sformatf({"result mismatch: expected status=%0d unit=%0d port=%0d last=%0b,",
				" got status=%0d unit=%0d port=%0d last=%0b"},
				want.status, want.tu, want.tp, want.last, st, tu, tp, lst));
	endfunction
endclass

module connection_table_engine_unit_test;

	// receiver behavior between long hold-offs
	typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_style_t;

	localparam int LONG_HOLD    = 400;   // cycles of out_ready low to back the block up
	localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
	localparam int DRAIN_CYCLES = 2 * cte_pkg::TABLE_DEPTH + 8;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] func;
	logic [7:0] src_unit;
	logic [7:0] src_port;
	logic [7:0] sink_unit;
	logic [7:0] sink_port;
	logic [8:0] protected_in_ports;
	logic [8:0] protected_out_ports;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] status;
	logic [7:0] term_unit;
	logic [7:0] term_port;
	logic       last;

	conn_table_tracker tracker = new();

	int        burst_left   = 0;   // requests left in the current sender burst
	int        gap_max      = 0;   // 0: sender never idles
	rx_style_t rx_style     = RX_LIGHT;
	bit        hold_request = 1'b0;
	int        stall_left;
	int        idle_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	connection_table_engine_unit DUT (.*);

	// Both channels are sampled mid-cycle: inputs only move at the rising
	// edge, so what is seen here is what the next edge will transfer.
	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready)
			tracker.take_request(func, src_unit, src_port, sink_unit, sink_port,
				protected_in_ports, protected_out_ports);
		if (arst_n && out_valid && out_ready)
			tracker.match_result(status, term_unit, term_port, last);
	end

	// Watchdog: any transaction on either side resets the count.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stall runs whose density follows rx_style, plus one
	// long hold-off on request, timed here so the sender keeps pushing.
	initial begin
		out_ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (rx_style == RX_LIGHT && $urandom_range(0, 99) < 20)
					stall_left = $urandom_range(1, 3);
				else if (rx_style == RX_HEAVY && $urandom_range(0, 99) < 40)
					stall_left = $urandom_range(2, 12);
			end
		end
	end

	// Mostly a small pool so that sinks collide and lists find several hits;
	// sometimes any 8-bit value.
	function automatic logic [7:0] any_id();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 3));
	endfunction

	function automatic logic [8:0] any_guard();
		case ($urandom_range(0, 4))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			default: return 9'($urandom_range(0, 256));
		endcase
	endfunction

	// Offer one request and hold it until the transaction completes. Called
	// at a rising edge; returns at the edge that took the request. Idle gaps
	// go in front, so valid is written once per edge.
	task automatic send_op(input logic [2:0] op, input logic [7:0] su, sp, ku, kp,
			input logic [8:0] pin, pout);
		bit taken;
		if (gap_max > 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		in_valid            <= 1'b1;
		func                <= op;
		src_unit            <= su;
		src_port            <= sp;
		sink_unit           <= ku;
		sink_port           <= kp;
		protected_in_ports  <= pin;
		protected_out_ports <= pout;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sender goes quiet until every owed result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
	endtask

	// One random request. Disconnects and lookups mostly target links that
	// exist so the shift and hit paths get real work.
	task automatic random_op();
		int pick;
		int j;
		logic [7:0] su, sp, ku, kp;
		pick = $urandom_range(0, 99);
		su = any_id();
		sp = any_id();
		ku = any_id();
		kp = any_id();
		if (tracker.link_cnt > 0 && $urandom_range(0, 9) < 6) begin
			j = $urandom_range(0, tracker.link_cnt - 1);
			{su, sp, ku, kp} = tracker.links[j];
		end
		if (pick < 40)
			send_op(cte_pkg::F_CONNECT, su, sp, any_id(), any_id(), any_guard(), any_guard());
		else if (pick < 55)
			send_op(cte_pkg::F_DISCONNECT, su, sp, ku, kp, any_guard(), any_guard());
		else if (pick < 65)
			send_op(cte_pkg::F_SOURCE_OF, any_id(), any_id(), ku, kp, any_guard(), any_guard());
		else if (pick < 75)
			send_op(cte_pkg::F_SINKS_TERM, su, sp, ku, kp, any_guard(), any_guard());
		else if (pick < 83)
			send_op(cte_pkg::F_SINKS_UNIT, su, sp, ku, kp, any_guard(), any_guard());
		else if (pick < 91)
			send_op(cte_pkg::F_SOURCES_UNIT, ku, sp, su, kp, any_guard(), any_guard());
		else if (pick < 98)
			send_op(cte_pkg::F_REMOVE_UNIT, su, sp, ku, kp, any_guard(), any_guard());
		else
			send_op(cte_pkg::F_UNUSED, su, sp, ku, kp, any_guard(), any_guard());
	endtask

	initial begin
		arst_n              <= 1'b0;
		in_valid            <= 1'b0;
		func                <= cte_pkg::F_CONNECT;
		src_unit            <= '0;
		src_port            <= '0;
		sink_unit           <= '0;
		sink_port           <= '0;
		protected_in_ports  <= '0;
		protected_out_ports <= '0;
		gap_max = 4;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table misses, sink conflicts, lists, order-keeping
		// delete, protected-port removal at both extremes, unused opcode.
		send_op(cte_pkg::F_SOURCE_OF,    8'd5,   8'd5,   8'd5,   8'd5,   9'd0,   9'd0);
		send_op(cte_pkg::F_SINKS_UNIT,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_DISCONNECT,   8'd0,   8'd0,   8'd255, 8'd255, 9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd0,   8'd0,   8'd255, 8'd255, 9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd255, 8'd255, 8'd0,   8'd0,   9'd256, 9'd256);
		send_op(cte_pkg::F_CONNECT,      8'd0,   8'd0,   8'd255, 8'd255, 9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd7,   8'd3,   8'd255, 8'd255, 9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd0,   8'd0,   8'd1,   8'd1,   9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd0,   8'd0,   8'd1,   8'd2,   9'd0,   9'd0);
		send_op(cte_pkg::F_CONNECT,      8'd0,   8'd5,   8'd0,   8'd9,   9'd0,   9'd0);
		send_op(cte_pkg::F_SINKS_TERM,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_SINKS_UNIT,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_SOURCES_UNIT, 8'd1,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_SOURCE_OF,    8'd0,   8'd0,   8'd255, 8'd255, 9'd0,   9'd0);
		send_op(cte_pkg::F_UNUSED,       8'd255, 8'd255, 8'd255, 8'd255, 9'd256, 9'd256);
		send_op(cte_pkg::F_DISCONNECT,   8'd0,   8'd0,   8'd1,   8'd1,   9'd0,   9'd0);
		send_op(cte_pkg::F_SINKS_TERM,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd0,   8'd0,   8'd0,   8'd0,   9'd256, 9'd256);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd0,   8'd0,   8'd0,   8'd0,   9'd1,   9'd0);
		send_op(cte_pkg::F_SOURCES_UNIT, 8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd255, 8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		send_op(cte_pkg::F_SINKS_UNIT,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   9'd0);
		drain_results();

		// Fill past capacity while the receiver holds off: the block backs
		// up and stalls its input. The last few connects hit a full table,
		// then full-length lists and a partial removal.
		hold_request = 1'b1;
		gap_max = 0;
		for (int k = 0; k < cte_pkg::TABLE_DEPTH + 4; k++)
			send_op(cte_pkg::F_CONNECT, 8'd9, 8'(k % 4), 8'(128 + k / 8), 8'(k % 8),
				any_guard(), any_guard());
		send_op(cte_pkg::F_SINKS_UNIT,   8'd9,   8'd0, 8'd0,   8'd0, 9'd0, 9'd0);
		send_op(cte_pkg::F_SOURCES_UNIT, 8'd130, 8'd0, 8'd0,   8'd0, 9'd0, 9'd0);
		send_op(cte_pkg::F_SINKS_TERM,   8'd9,   8'd2, 8'd0,   8'd0, 9'd0, 9'd0);
		send_op(cte_pkg::F_SOURCE_OF,    8'd0,   8'd0, 8'd135, 8'd7, 9'd0, 9'd0);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd9,   8'd0, 8'd0,   8'd0, 9'd2, 9'd0);
		send_op(cte_pkg::F_SINKS_UNIT,   8'd9,   8'd0, 8'd0,   8'd0, 9'd0, 9'd0);
		send_op(cte_pkg::F_REMOVE_UNIT,  8'd9,   8'd0, 8'd0,   8'd0, 9'd0, 9'd0);
		drain_results();

		// Random traffic: a stretch with no idling, then light and heavy
		// idling on both sides.
		for (int c = 0; c < 3; c++) begin
			case (c)
				0: begin gap_max = 0;  rx_style = RX_STEADY; end
				1: begin gap_max = 6;  rx_style = RX_LIGHT;  end
				default: begin gap_max = 15; rx_style = RX_HEAVY; end
			endcase
			repeat (28) random_op();
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.fault_count == 0 && tracker.awaited.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
